// File: hdl/pbt_pkg.sv
// ----------------------------------------------------------------------------
// pbt_pkg: shared types for the protected block table
// Opcodes, status codes, controller states and the command/status structs.
// ----------------------------------------------------------------------------
package pbt_pkg;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_QPROT  = 2'd1,
		OP_QMEMB  = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_DUP  = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FINISH
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;    // capture the request, restart the scan
		logic scan;    // walk the table one slot per cycle
		logic finish;  // update the table, load the result register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic hit;       // the entry compared this cycle holds the key
		logic scan_end;  // every stored entry has been compared
	} sts_t;

endpackage

// File: hdl/pbt_ctrl.sv
// ----------------------------------------------------------------------------
// pbt_ctrl: request sequencer
// Accepts a request, runs the table scan (clear skips it), then hands the result
// to the output register when it is free or being drained.
// ----------------------------------------------------------------------------
module pbt_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic [1:0]      opcode,
	output logic            out_valid,
	input  logic            out_stall,
	output pbt_pkg::cmd_t   cmd,
	input  pbt_pkg::sts_t   sts
);

	pbt_pkg::state_t state_q;
	pbt_pkg::state_t state_nxt;
	logic            out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pbt_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt  = state_q;
		cmd        = '0;
		in_stall   = 1'b1;
		case (state_q)
			pbt_pkg::S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					// clear needs no lookup
					if (pbt_pkg::op_t'(opcode) == pbt_pkg::OP_CLEAR) begin
						state_nxt = pbt_pkg::S_FINISH;
					end else begin
						state_nxt = pbt_pkg::S_SCAN;
					end
				end
			end
			pbt_pkg::S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.hit || sts.scan_end) begin
					state_nxt = pbt_pkg::S_FINISH;
				end
			end
			pbt_pkg::S_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					cmd.finish = 1'b1;
					state_nxt  = pbt_pkg::S_IDLE;
				end
			end
			default: begin
				state_nxt = pbt_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// File: hdl/pbt_dpath.sv
// ----------------------------------------------------------------------------
// pbt_dpath: table storage, scan compare and result register
// Entries occupy slots 0..count-1; the fill count stands in for valid bits.
// ----------------------------------------------------------------------------
module pbt_dpath #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [1:0]      opcode,
	input  logic [31:0]     block_number,
	input  logic [63:0]     seq_number,
	input  pbt_pkg::cmd_t   cmd,
	output pbt_pkg::sts_t   sts,
	output logic            found,
	output logic            is_protected,
	output logic [1:0]      status
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

	logic [31:0]     mem_block [TABLE_DEPTH];
	logic [63:0]     mem_seq   [TABLE_DEPTH];

	pbt_pkg::op_t    op_q;
	logic [31:0]     key_q;
	logic [63:0]     lsn_q;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   idx_q;
	logic            rd_vld_s1;
	logic [31:0]     rd_block_s1;
	logic [63:0]     rd_seq_s1;
	logic            hit_q;
	logic            newer_q;
	logic            found_q;
	logic            prot_q;
	logic [1:0]      status_q;

	logic            rd_issue;
	logic            key_eq;
	logic            seq_gt;
	logic            full;
	logic            do_write;

	assign rd_issue = cmd.scan && (idx_q != count_q);
	assign key_eq   = rd_block_s1 == key_q;
	assign seq_gt   = rd_seq_s1 > lsn_q;
	assign full     = count_q == DEPTH_C;
	assign do_write = cmd.finish && (op_q == pbt_pkg::OP_INSERT) && !hit_q && !full;

	assign sts.hit      = rd_vld_s1 && key_eq;
	assign sts.scan_end = !rd_vld_s1 && (idx_q == count_q);

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= pbt_pkg::op_t'(opcode);
			key_q <= block_number;
			lsn_q <= seq_number;
		end
	end

	// memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (do_write) begin
			mem_block[count_q[AW-1:0]] <= key_q;
			mem_seq[count_q[AW-1:0]]   <= lsn_q;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_issue) begin
			rd_block_s1 <= mem_block[idx_q[AW-1:0]];
			rd_seq_s1   <= mem_seq[idx_q[AW-1:0]];
		end
	end

	// scan control and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			rd_vld_s1 <= 1'b0;
			hit_q     <= 1'b0;
			count_q   <= '0;
		end else begin
			rd_vld_s1 <= rd_issue;
			if (cmd.load) begin
				idx_q <= '0;
				hit_q <= 1'b0;
			end else if (rd_issue) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.scan && sts.hit) begin
				hit_q <= 1'b1;
			end
			if (cmd.finish && op_q == pbt_pkg::OP_CLEAR) begin
				count_q <= '0;
			end else if (do_write) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan && sts.hit) begin
			newer_q <= seq_gt;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			found_q <= hit_q;
			prot_q  <= hit_q && (op_q == pbt_pkg::OP_QPROT) && newer_q;
			if (op_q == pbt_pkg::OP_INSERT && hit_q) begin
				status_q <= pbt_pkg::ST_DUP;
			end else if (op_q == pbt_pkg::OP_INSERT && full) begin
				status_q <= pbt_pkg::ST_FULL;
			end else begin
				status_q <= pbt_pkg::ST_OK;
			end
		end
	end

	assign found        = found_q;
	assign is_protected = prot_q;
	assign status       = status_q;

endmodule

// File: hdl/protected_block_table.sv
// Requests are taken one at a time: a new request is accepted only after the last
// one has finished. Lookups scan the table, comparing one stored entry per cycle;
// a hit ends the scan early, and clear skips the scan.
// A stalled result holds back the finish step and with it the next request.
// Reset: asynchronous, active low; fill count goes to zero, no clearing pass is run.
// ----------------------------------------------------------------------------
// protected_block_table: associative table of protected blocks with LSNs
// Insert, protect query, membership query and clear over a linear-scan table.
// ----------------------------------------------------------------------------
module protected_block_table #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [31:0] block_number,
	input  logic [63:0] seq_number,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic        found,
	output logic        is_protected,
	output logic [1:0]  status
);

	// Controller and datapath talk only through these two structs.
	pbt_pkg::cmd_t cmd;
	pbt_pkg::sts_t sts;

	// The controller owns the handshakes: it takes a request only when idle,
	// and it finishes a request only when the result register is empty or
	// is being drained, so a stalled result holds the finish step until it
	// leaves.
	pbt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.opcode    (opcode),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	// The datapath holds the entries in two memories, walks them with a
	// registered read, and appends new entries at the fill count.
	pbt_dpath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.opcode       (opcode),
		.block_number (block_number),
		.seq_number   (seq_number),
		.cmd          (cmd),
		.sts          (sts),
		.found        (found),
		.is_protected (is_protected),
		.status       (status)
	);

endmodule

// File: hdl/pbt_checker.sv
// ----------------------------------------------------------------------------
// pbt_checker: port-level assertions for the protected block table
// Bound to the top level; watches the two channels only.
// ----------------------------------------------------------------------------
module pbt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic        found,
	input logic        is_protected,
	input logic [1:0]  status
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(found) &&
			$stable(is_protected) && $stable(status))
		else $error("result changed while stalled");

	// one request at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken while busy");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != 2'd3)
		else $error("undefined status code");

	a_dup_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == pbt_pkg::ST_DUP |-> found)
		else $error("duplicate without found");

	a_prot_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_protected |-> found && status == pbt_pkg::ST_OK)
		else $error("protected without a plain hit");

endmodule

bind protected_block_table pbt_checker u_pbt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.found        (found),
	.is_protected (is_protected),
	.status       (status)
);

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the protected block table
// Drives insert, protect-query, member-query and clear requests. Each accepted
// request is run through a behavioral copy of the table. Every result is
// checked in order against that prediction, with random gaps and stalls.
// ----------------------------------------------------------------------------
module testbench;
	import pbt_pkg::*;

	localparam int TABLE_DEPTH  = 64;
	localparam int RANDOM_ITEMS = 1300;
	localparam int CYCLE_LIMIT  = 1000000;
	// quiet window: neither side idles while the request count is in this range
	localparam int STEADY_FROM  = 500;
	localparam int STEADY_TO    = 700;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  opcode;
	logic [31:0] block_number;
	logic [63:0] seq_number;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        found;
	logic        is_protected;
	logic [1:0]  status;

	int sent_requests = 0;
	int cycle_count = 0;
	bit steady = 1'b0;

	// Behavioral copy of the table plus the queue of answers still owed.
	// Slots 0..fill-1 hold the live entries, filled in order of insertion.
	class protect_table_tracker;
		typedef struct {
			logic    found;
			logic    prot;
			status_t status;
		} answer_t;

		bit [31:0] keys [TABLE_DEPTH];
		bit [63:0] lsns [TABLE_DEPTH];
		int        fill;
		answer_t   pending_answers [$];
		int        errors;

		function int find_slot(bit [31:0] key);
			for (int i = 0; i < fill; i++) begin
				if (keys[i] == key)
					return i;
			end
			return -1;
		endfunction

		// Called at the edge where a request is accepted.
		function void note_request(op_t op, bit [31:0] key, bit [63:0] lsn);
			answer_t a;
			int slot;
			a.found = 1'b0;
			a.prot = 1'b0;
			a.status = ST_OK;
			case (op)
				OP_INSERT: begin
					slot = find_slot(key);
					// duplicate check wins over full
					if (slot >= 0) begin
						a.found = 1'b1;
						a.status = ST_DUP;
					end else if (fill >= TABLE_DEPTH) begin
						a.status = ST_FULL;
					end else begin
						keys[fill] = key;
						lsns[fill] = lsn;
						fill++;
					end
				end
				OP_QPROT: begin
					slot = find_slot(key);
					if (slot >= 0) begin
						a.found = 1'b1;
						a.prot = lsns[slot] > lsn;
					end
				end
				OP_QMEMB: a.found = find_slot(key) >= 0;
				default: fill = 0;
			endcase
			pending_answers.push_back(a);
		endfunction

		function void check_answer(logic f, logic p, logic [1:0] s);
			answer_t want;
			if (pending_answers.size() == 0) begin
				$display("%0t: unexpected result found=%b is_protected=%b status=%0d",
					$time, f, p, s);
				errors++;
				return;
			end
			want = pending_answers.pop_front();
			if (f !== want.found) begin
				$display("%0t: found expected %b actual %b", $time, want.found, f);
				errors++;
			end
			if (p !== want.prot) begin
				$display("%0t: is_protected expected %b actual %b", $time, want.prot, p);
				errors++;
			end
			if (s !== want.status) begin
				$display("%0t: status expected %0d actual %0d", $time, want.status, s);
				errors++;
			end
		endfunction
	endclass

	protect_table_tracker tracker = new();

	protected_block_table #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.block_number(block_number),
		.seq_number(seq_number),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.found(found),
		.is_protected(is_protected),
		.status(status)
	);

	always #5 clk = ~clk;

	// watchdog: a hung handshake ends the run as a failure
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	// result side: stall decided at the falling edge, result taken at the rising edge
	always @(negedge clk) begin
		out_stall <= !steady && ($urandom_range(0, 99) < 30);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			tracker.check_answer(found, is_protected, status);
	end

	function automatic bit [63:0] rand_lsn();
		return {$urandom, $urandom};
	endfunction

	// LSN close to a stored one so the strict greater-than edge gets hit
	function automatic bit [63:0] lsn_near(bit [63:0] stored);
		case ($urandom_range(0, 5))
			0: return stored;
			1: return stored - 64'd1;
			2: return stored + 64'd1;
			3: return 64'd0;
			4: return '1;
			default: return rand_lsn();
		endcase
	endfunction

	// One request: random gap first, then hold the payload until accepted.
	task automatic send_request(op_t op, bit [31:0] key, bit [63:0] lsn);
		steady = sent_requests >= STEADY_FROM && sent_requests < STEADY_TO;
		@(negedge clk);
		while (!steady && $urandom_range(0, 99) < 30) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		block_number <= key;
		seq_number <= lsn;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		tracker.note_request(op, key, lsn);
		sent_requests++;
	endtask

	// Clear, then a burst of inserts mixed with queries on live and absent keys.
	// About one burst in four runs past the table depth to hit the full case.
	task automatic run_burst();
		int target;
		int steps;
		int pick;
		int slot;
		bit [31:0] base;
		bit [31:0] key;
		base = $urandom;
		if ($urandom_range(0, 3) == 0)
			target = $urandom_range(TABLE_DEPTH - 4, TABLE_DEPTH + 8);
		else
			target = $urandom_range(1, 20);
		steps = 3 * target + 4;
		send_request(OP_CLEAR, $urandom, rand_lsn());
		for (int n = 0; n < steps; n++) begin
			pick = $urandom_range(0, 99);
			// new keys: half from a narrow window so neighbors and repeats show up
			key = $urandom_range(0, 1) ? $urandom : base + $urandom_range(0, 255);
			slot = tracker.fill > 0 ? $urandom_range(0, tracker.fill - 1) : -1;
			if (pick < 2) begin
				// noise: clear in the middle of a burst
				send_request(OP_CLEAR, $urandom, rand_lsn());
			end else if (pick < 50 || slot < 0) begin
				send_request(OP_INSERT, key, rand_lsn());
			end else if (pick < 60) begin
				// duplicate with a new LSN; the stored one must survive
				send_request(OP_INSERT, tracker.keys[slot], rand_lsn());
			end else if (pick < 80) begin
				send_request(OP_QPROT, tracker.keys[slot], lsn_near(tracker.lsns[slot]));
			end else if (pick < 88) begin
				send_request(OP_QMEMB, tracker.keys[slot], rand_lsn());
			end else begin
				// likely miss: neighbor of a live key or a fresh one
				if ($urandom_range(0, 1))
					key = tracker.keys[slot] ^ (32'd1 << $urandom_range(0, 31));
				send_request($urandom_range(0, 1) ? OP_QPROT : OP_QMEMB, key,
					lsn_near(tracker.lsns[slot]));
			end
		end
	endtask

	initial begin
		int random_from;
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = OP_INSERT;
		block_number = '0;
		seq_number = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: empty-table lookups
		send_request(OP_QMEMB, 32'h0, 64'h0);
		send_request(OP_QPROT, '1, '1);
		// key and LSN extremes
		send_request(OP_INSERT, 32'h0, 64'h0);
		send_request(OP_INSERT, '1, '1);
		// duplicate keeps the first LSN
		send_request(OP_INSERT, 32'h0, 64'd5);
		send_request(OP_QPROT, 32'h0, 64'h0);
		send_request(OP_QPROT, '1, 64'hFFFF_FFFF_FFFF_FFFE);
		send_request(OP_QPROT, '1, '1);
		// strictly greater: below, equal, above the stored LSN
		send_request(OP_INSERT, 32'h0000_1234, 64'd100);
		send_request(OP_QPROT, 32'h0000_1234, 64'd99);
		send_request(OP_QPROT, 32'h0000_1234, 64'd100);
		send_request(OP_QPROT, 32'h0000_1234, 64'd101);
		send_request(OP_QMEMB, 32'h0000_1234, 64'h0);
		send_request(OP_QMEMB, 32'h0000_1235, 64'h0);
		send_request(OP_QPROT, 32'h8000_0000, 64'h8000_0000_0000_0000);
		send_request(OP_INSERT, 32'hA5A5_5A5A, 64'h5A5A_A5A5_0F0F_F0F0);
		send_request(OP_QPROT, 32'hA5A5_5A5A, 64'h0);
		// clear with busy fields, then the old keys are gone and can come back
		send_request(OP_CLEAR, '1, '1);
		send_request(OP_QMEMB, 32'h0, 64'h0);
		send_request(OP_QPROT, 32'h0000_1234, 64'h0);
		send_request(OP_INSERT, 32'h0, 64'd7);
		send_request(OP_QPROT, 32'h0, 64'd6);
		send_request(OP_CLEAR, 32'h0, 64'h0);

		random_from = sent_requests;
		while (sent_requests - random_from < RANDOM_ITEMS)
			run_burst();

		@(negedge clk);
		in_valid <= 1'b0;
		while (tracker.pending_answers.size() != 0)
			@(posedge clk);
		// a stray result would show up within one full scan
		repeat (TABLE_DEPTH + 8) @(posedge clk);

		if (tracker.errors == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule

// File: filelist.f
hdl/pbt_pkg.sv
hdl/pbt_ctrl.sv
hdl/pbt_dpath.sv
hdl/protected_block_table.sv
hdl/pbt_checker.sv
dv/testbench.sv
